FILE: rtl/multi_pattern_match_marker_unit_macros.svh
// Assertion macros for the pattern matcher.
`ifndef MULTI_PATTERN_MATCH_MARKER_UNIT_MACROS_SVH
`define MULTI_PATTERN_MATCH_MARKER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MPM_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("assertion failed");
`define MPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MPM_ASSERT_NEVER(lbl, clk, rstn, cond)
`define MPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/mpm_pkg.sv
package mpm_pkg;

	localparam int MAX_NODES_DEF   = 1024;
	localparam int MAX_PATTERN_LEN = 255;
	localparam int LEN_CAP         = (MAX_PATTERN_LEN < 255) ? MAX_PATTERN_LEN : 255;
	localparam int PAIR_LIMIT      = 128;
	localparam int PAIR_SHIFT      = 8;
	localparam int KEY_W           = 24;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_SCAN  = 2'd2;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_ACCEPT,
		CMD_PREP,
		CMD_BUILD_INIT,
		CMD_FC_RD,
		CMD_FC_TAKE,
		CMD_KS_RD,
		CMD_KS_NEXT,
		CMD_FAIL_RD,
		CMD_FAIL_TAKE,
		CMD_LOAD_MOVE,
		CMD_LOAD_OVF,
		CMD_NEW1,
		CMD_NEW2,
		CMD_LOAD_STAT,
		CMD_MLEN_L,
		CMD_LOAD_REC,
		CMD_MLEN_C,
		CMD_SCAN_MISS,
		CMD_SCAN_LEN,
		CMD_Q_RD,
		CMD_U_TAKE,
		CMD_UFC_RD,
		CMD_UFC_TAKE,
		CMD_V_RD,
		CMD_V_TAKE,
		CMD_UFAIL_RD,
		CMD_F_SET,
		CMD_SETF,
		CMD_MLEN_V,
		CMD_MLEN_F
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       pair_hold;
		logic       last;
		logic       ovf;
		logic       full;
		logic       c_zero;
		logic       key_hit;
		logic       nx_zero;
		logic       u_zero;
		logic       v_zero;
		logic       q_empty;
	} stat_t;

endpackage

FILE: rtl/multi_pattern_match_marker_unit.sv
// Ops: a held wide unit (load or scan) or unused op 3 goes straight to done; load compares
// child keys, adds a new node on a miss (or marks overflow if the table is full) and records
// a last unit; once overflowed it skips the search; scan compares child keys, follows fail
// hops on a miss; build takes each node from the queue and sets fail links of its children.
// A new request is taken only while idle; done lasts one cycle, no receiver stall.
// Reset: arst_n clears cursors, counts and state at once; node entries are written on creation.
`include "multi_pattern_match_marker_unit_macros.svh"

module multi_pattern_match_marker_unit #(
	parameter int MAX_NODES = mpm_pkg::MAX_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] code_unit,
	input  logic        last_unit,
	output logic        done,
	output logic [7:0]  match_len,
	output logic        status
);

	mpm_pkg::cmd_t  cmd;
	mpm_pkg::stat_t stat;

	mpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mpm_dp #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.opcode    (opcode),
		.code_unit (code_unit),
		.last_unit (last_unit),
		.match_len (match_len),
		.status    (status),
		.stat      (stat)
	);

	`MPM_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`MPM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`MPM_ASSERT_NEVER(a_len_or_status, clk, arst_n, done && status && (match_len != 8'd0))

endmodule

FILE: rtl/mpm_ram.sv
module mpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/mpm_ctrl.sv
module mpm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mpm_pkg::stat_t stat,
	output mpm_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [21:0] {
		ST_IDLE     = 22'h000001,
		ST_DISPATCH = 22'h000002,
		ST_F_FC     = 22'h000004,
		ST_F_FCW    = 22'h000008,
		ST_F_CH     = 22'h000010,
		ST_F_CK     = 22'h000020,
		ST_FL_WAIT  = 22'h000040,
		ST_L_NEW2   = 22'h000080,
		ST_L_LAST   = 22'h000100,
		ST_L_REC    = 22'h000200,
		ST_S_LEN    = 22'h000400,
		ST_B_POP    = 22'h000800,
		ST_B_U      = 22'h001000,
		ST_B_FC     = 22'h002000,
		ST_B_FCW    = 22'h004000,
		ST_B_V      = 22'h008000,
		ST_B_VK     = 22'h010000,
		ST_B_UF     = 22'h020000,
		ST_B_SETF   = 22'h040000,
		ST_B_MV     = 22'h080000,
		ST_B_MF     = 22'h100000,
		ST_DONE     = 22'h200000
	} state_t;

	typedef enum logic [1:0] {
		CTX_LOAD,
		CTX_SCAN,
		CTX_BUILD
	} ctx_t;

	state_t state_q, state_d;
	ctx_t   ctx_q, ctx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctx_q   <= CTX_LOAD;
		end else begin
			state_q <= state_d;
			ctx_q   <= ctx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctx_d   = ctx_q;
		cmd     = mpm_pkg::CMD_NOP;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd     = mpm_pkg::CMD_ACCEPT;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (stat.op)
					mpm_pkg::OP_LOAD: begin
						cmd   = mpm_pkg::CMD_PREP;
						ctx_d = CTX_LOAD;
						if (stat.pair_hold)
							state_d = ST_DONE;
						else if (stat.ovf)
							state_d = ST_L_LAST;
						else
							state_d = ST_F_FC;
					end
					mpm_pkg::OP_SCAN: begin
						cmd     = mpm_pkg::CMD_PREP;
						ctx_d   = CTX_SCAN;
						state_d = stat.pair_hold ? ST_DONE : ST_F_FC;
					end
					mpm_pkg::OP_BUILD: begin
						cmd     = mpm_pkg::CMD_BUILD_INIT;
						ctx_d   = CTX_BUILD;
						state_d = ST_B_POP;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_F_FC: begin
				cmd     = mpm_pkg::CMD_FC_RD;
				state_d = ST_F_FCW;
			end
			ST_F_FCW: begin
				cmd     = mpm_pkg::CMD_FC_TAKE;
				state_d = ST_F_CH;
			end
			ST_F_CH: begin
				if (!stat.c_zero) begin
					cmd     = mpm_pkg::CMD_KS_RD;
					state_d = ST_F_CK;
				end else begin
					// no child with this key under the search node
					case (ctx_q)
						CTX_LOAD: begin
							if (stat.full) begin
								cmd     = mpm_pkg::CMD_LOAD_OVF;
								state_d = ST_L_LAST;
							end else begin
								cmd     = mpm_pkg::CMD_NEW1;
								state_d = ST_L_NEW2;
							end
						end
						CTX_SCAN: begin
							if (stat.nx_zero) begin
								cmd     = mpm_pkg::CMD_SCAN_MISS;
								state_d = ST_DONE;
							end else begin
								cmd     = mpm_pkg::CMD_FAIL_RD;
								state_d = ST_FL_WAIT;
							end
						end
						CTX_BUILD: begin
							if (stat.nx_zero) begin
								state_d = ST_B_SETF;
							end else begin
								cmd     = mpm_pkg::CMD_FAIL_RD;
								state_d = ST_FL_WAIT;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_F_CK: begin
				if (stat.key_hit) begin
					case (ctx_q)
						CTX_LOAD: begin
							cmd     = mpm_pkg::CMD_LOAD_MOVE;
							state_d = ST_L_LAST;
						end
						CTX_SCAN: begin
							cmd     = mpm_pkg::CMD_MLEN_C;
							state_d = ST_S_LEN;
						end
						CTX_BUILD: begin
							cmd     = mpm_pkg::CMD_F_SET;
							state_d = ST_B_SETF;
						end
						default: state_d = ST_DONE;
					endcase
				end else begin
					cmd     = mpm_pkg::CMD_KS_NEXT;
					state_d = ST_F_CH;
				end
			end
			ST_FL_WAIT: begin
				cmd     = mpm_pkg::CMD_FAIL_TAKE;
				state_d = ST_F_FC;
			end
			ST_L_NEW2: begin
				cmd     = mpm_pkg::CMD_NEW2;
				state_d = ST_L_LAST;
			end
			ST_L_LAST: begin
				if (stat.last && !stat.ovf) begin
					cmd     = mpm_pkg::CMD_MLEN_L;
					state_d = ST_L_REC;
				end else begin
					cmd     = mpm_pkg::CMD_LOAD_STAT;
					state_d = ST_DONE;
				end
			end
			ST_L_REC: begin
				cmd     = mpm_pkg::CMD_LOAD_REC;
				state_d = ST_DONE;
			end
			ST_S_LEN: begin
				cmd     = mpm_pkg::CMD_SCAN_LEN;
				state_d = ST_DONE;
			end
			ST_B_POP: begin
				if (stat.q_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd     = mpm_pkg::CMD_Q_RD;
					state_d = ST_B_U;
				end
			end
			ST_B_U: begin
				cmd     = mpm_pkg::CMD_U_TAKE;
				state_d = ST_B_FC;
			end
			ST_B_FC: begin
				cmd     = mpm_pkg::CMD_UFC_RD;
				state_d = ST_B_FCW;
			end
			ST_B_FCW: begin
				cmd     = mpm_pkg::CMD_UFC_TAKE;
				state_d = ST_B_V;
			end
			ST_B_V: begin
				if (stat.v_zero) begin
					state_d = ST_B_POP;
				end else begin
					cmd     = mpm_pkg::CMD_V_RD;
					state_d = ST_B_VK;
				end
			end
			ST_B_VK: begin
				cmd     = mpm_pkg::CMD_V_TAKE;
				state_d = stat.u_zero ? ST_B_SETF : ST_B_UF;
			end
			ST_B_UF: begin
				cmd     = mpm_pkg::CMD_UFAIL_RD;
				state_d = ST_FL_WAIT;
			end
			ST_B_SETF: begin
				cmd     = mpm_pkg::CMD_SETF;
				state_d = ST_B_MV;
			end
			ST_B_MV: begin
				cmd     = mpm_pkg::CMD_MLEN_V;
				state_d = ST_B_MF;
			end
			ST_B_MF: begin
				cmd     = mpm_pkg::CMD_MLEN_F;
				state_d = ST_B_V;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

FILE: rtl/mpm_dp.sv
module mpm_dp #(
	parameter int MAX_NODES = mpm_pkg::MAX_NODES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mpm_pkg::cmd_t  cmd,
	input  logic [1:0]     opcode,
	input  logic [15:0]    code_unit,
	input  logic           last_unit,
	output logic [7:0]     match_len,
	output logic           status,
	output mpm_pkg::stat_t stat
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = NW + 1;
	localparam int KW = mpm_pkg::KEY_W;

	logic [1:0]    op_q;
	logic [15:0]   unit_q;
	logic          last_q;
	logic          pend_v_q;
	logic [15:0]   pend_hi_q;
	logic [KW-1:0] key_q;
	logic [7:0]    luc_q;
	logic          ovf_q;
	logic [NW-1:0] lcur_q, scur_q, nx_q, c_q, fc0_q, u_q, v_q, vsib_q, f_q, rootfc_q;
	logic [CW-1:0] ncnt_q, head_q, tail_q;
	logic [7:0]    mlenv_q, len_q;
	logic          st_q;

	logic          fc_we, ks_we, fl_we, ml_we, q_we;
	logic [NW-1:0] fc_wa, fc_wd, fc_ra, fc_rd;
	logic [NW-1:0] ks_wa, ks_ra, sib_wd, sib_rd;
	logic [KW-1:0] key_wd, key_rd;
	logic [NW-1:0] fl_wa, fl_wd, fl_ra, fl_rd;
	logic [NW-1:0] ml_wa, ml_ra;
	logic [7:0]    ml_wd, ml_rd;
	logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;

	logic          pair_hold;
	logic [KW-1:0] key_new;
	logic [NW-1:0] new_idx;

	// a wide unit that is not last waits for its partner
	assign pair_hold = !pend_v_q && !last_q && (unit_q > 16'(mpm_pkg::PAIR_LIMIT));

	assign key_new = pend_v_q ?
		(({8'd0, pend_hi_q} << mpm_pkg::PAIR_SHIFT) | {8'd0, unit_q}) : {8'd0, unit_q};
	assign new_idx = ncnt_q[NW-1:0];

	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fc_ram (
		.clk(clk), .we(fc_we), .waddr(fc_wa), .wdata(fc_wd), .raddr(fc_ra), .rdata(fc_rd));
	mpm_ram #(.WIDTH(KW), .DEPTH(MAX_NODES)) u_key_ram (
		.clk(clk), .we(ks_we), .waddr(ks_wa), .wdata(key_wd), .raddr(ks_ra), .rdata(key_rd));
	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_sib_ram (
		.clk(clk), .we(ks_we), .waddr(ks_wa), .wdata(sib_wd), .raddr(ks_ra), .rdata(sib_rd));
	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail_ram (
		.clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
	mpm_ram #(.WIDTH(8), .DEPTH(MAX_NODES)) u_mlen_ram (
		.clk(clk), .we(ml_we), .waddr(ml_wa), .wdata(ml_wd), .raddr(ml_ra), .rdata(ml_rd));
	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_q_ram (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

	// memory ports
	always_comb begin
		fc_we  = 1'b0;
		fc_wa  = new_idx;
		fc_wd  = '0;
		fc_ra  = nx_q;
		ks_we  = 1'b0;
		ks_wa  = new_idx;
		key_wd = key_q;
		sib_wd = fc0_q;
		ks_ra  = c_q;
		fl_we  = 1'b0;
		fl_wa  = new_idx;
		fl_wd  = '0;
		fl_ra  = nx_q;
		ml_we  = 1'b0;
		ml_wa  = new_idx;
		ml_wd  = '0;
		ml_ra  = lcur_q;
		q_we   = 1'b0;
		q_wa   = tail_q[NW-1:0];
		q_wd   = v_q;
		q_ra   = head_q[NW-1:0];
		case (cmd)
			mpm_pkg::CMD_UFC_RD:   fc_ra = u_q;
			mpm_pkg::CMD_V_RD:     ks_ra = v_q;
			mpm_pkg::CMD_UFAIL_RD: fl_ra = u_q;
			mpm_pkg::CMD_MLEN_C:   ml_ra = c_q;
			mpm_pkg::CMD_MLEN_V:   ml_ra = f_q;
			mpm_pkg::CMD_SETF: begin
				fl_we = 1'b1;
				fl_wa = v_q;
				fl_wd = f_q;
				ml_ra = v_q;
			end
			mpm_pkg::CMD_NEW1: begin
				// fresh node: key, sibling link, and cleared child/fail/length
				fc_we = 1'b1;
				ks_we = 1'b1;
				fl_we = 1'b1;
				ml_we = 1'b1;
			end
			mpm_pkg::CMD_NEW2: begin
				fc_we = (lcur_q != '0);
				fc_wa = lcur_q;
				fc_wd = new_idx;
			end
			mpm_pkg::CMD_LOAD_REC: begin
				ml_we = (luc_q > ml_rd);
				ml_wa = lcur_q;
				ml_wd = luc_q;
			end
			mpm_pkg::CMD_MLEN_F: begin
				ml_we = (f_q != '0) && (ml_rd > mlenv_q);
				ml_wa = v_q;
				ml_wd = ml_rd;
				q_we  = 1'b1;
			end
			mpm_pkg::CMD_BUILD_INIT: begin
				q_we = 1'b1;
				q_wa = '0;
				q_wd = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q      <= '0;
			unit_q    <= '0;
			last_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_hi_q <= '0;
			key_q     <= '0;
			luc_q     <= '0;
			ovf_q     <= 1'b0;
			lcur_q    <= '0;
			scur_q    <= '0;
			nx_q      <= '0;
			c_q       <= '0;
			fc0_q     <= '0;
			u_q       <= '0;
			v_q       <= '0;
			vsib_q    <= '0;
			f_q       <= '0;
			rootfc_q  <= '0;
			ncnt_q    <= CW'(1);
			head_q    <= '0;
			tail_q    <= '0;
			mlenv_q   <= '0;
			len_q     <= '0;
			st_q      <= 1'b0;
		end else begin
			case (cmd)
				mpm_pkg::CMD_ACCEPT: begin
					op_q   <= opcode;
					unit_q <= code_unit;
					last_q <= last_unit;
					len_q  <= '0;
					st_q   <= 1'b0;
				end
				mpm_pkg::CMD_PREP: begin
					if (op_q == mpm_pkg::OP_LOAD && luc_q < 8'(mpm_pkg::LEN_CAP))
						luc_q <= luc_q + 8'd1;
					if (pair_hold) begin
						pend_v_q  <= 1'b1;
						pend_hi_q <= unit_q;
					end else begin
						key_q     <= key_new;
						pend_v_q  <= 1'b0;
						pend_hi_q <= '0;
					end
					nx_q <= (op_q == mpm_pkg::OP_LOAD) ? lcur_q : scur_q;
				end
				mpm_pkg::CMD_BUILD_INIT: begin
					pend_v_q  <= 1'b0;
					pend_hi_q <= '0;
					head_q    <= '0;
					tail_q    <= CW'(1);
				end
				mpm_pkg::CMD_FC_TAKE: begin
					c_q   <= (nx_q == '0) ? rootfc_q : fc_rd;
					fc0_q <= (nx_q == '0) ? rootfc_q : fc_rd;
				end
				mpm_pkg::CMD_KS_NEXT:   c_q <= sib_rd;
				mpm_pkg::CMD_FAIL_TAKE: nx_q <= fl_rd;
				mpm_pkg::CMD_LOAD_MOVE: lcur_q <= c_q;
				mpm_pkg::CMD_LOAD_OVF:  ovf_q <= 1'b1;
				mpm_pkg::CMD_NEW2: begin
					if (lcur_q == '0)
						rootfc_q <= new_idx;
					lcur_q <= new_idx;
					ncnt_q <= ncnt_q + CW'(1);
				end
				mpm_pkg::CMD_LOAD_STAT: begin
					st_q <= ovf_q;
					if (last_q) begin
						lcur_q <= '0;
						luc_q  <= '0;
						ovf_q  <= 1'b0;
					end
				end
				mpm_pkg::CMD_LOAD_REC: begin
					lcur_q <= '0;
					luc_q  <= '0;
					ovf_q  <= 1'b0;
				end
				mpm_pkg::CMD_SCAN_MISS: begin
					len_q  <= '0;
					scur_q <= '0;
				end
				mpm_pkg::CMD_SCAN_LEN: begin
					len_q  <= ml_rd;
					scur_q <= last_q ? '0 : c_q;
				end
				mpm_pkg::CMD_Q_RD:     head_q <= head_q + CW'(1);
				mpm_pkg::CMD_U_TAKE:   u_q <= q_rd;
				mpm_pkg::CMD_UFC_TAKE: v_q <= (u_q == '0) ? rootfc_q : fc_rd;
				mpm_pkg::CMD_V_TAKE: begin
					key_q  <= key_rd;
					vsib_q <= sib_rd;
					f_q    <= '0;
				end
				mpm_pkg::CMD_F_SET:  f_q <= c_q;
				mpm_pkg::CMD_MLEN_V: mlenv_q <= ml_rd;
				mpm_pkg::CMD_MLEN_F: begin
					tail_q <= tail_q + CW'(1);
					v_q    <= vsib_q;
				end
				default: ;
			endcase
		end
	end

	assign stat.op        = op_q;
	assign stat.pair_hold = pair_hold;
	assign stat.last      = last_q;
	assign stat.ovf       = ovf_q;
	assign stat.full      = (ncnt_q == CW'(MAX_NODES));
	assign stat.c_zero    = (c_q == '0);
	assign stat.key_hit   = (key_rd == key_q);
	assign stat.nx_zero   = (nx_q == '0);
	assign stat.u_zero    = (u_q == '0);
	assign stat.v_zero    = (v_q == '0);
	assign stat.q_empty   = (head_q == tail_q);

	assign match_len = len_q;
	assign status    = st_q;

endmodule
